/* rtl/gws_pkg.sv */
// Shared types, constants and helpers for the grid word search unit.
// No dependencies.
package gws_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int ADDR_W      = $clog2(MAX_COLUMNS);
	localparam int CFG_COLS_W  = 11;
	localparam int WORD_W      = 40;
	localparam int HIST_W      = 32;
	localparam int CHAR_W      = 8;
	localparam int WINDOW_BACK = 4;
	localparam int ROWS_W      = 3;
	localparam int MAXC_W      = $clog2(MAX_COLUMNS + 1);
	localparam int CMP_W       = ((MAXC_W > CFG_COLS_W) ? MAXC_W : CFG_COLS_W) + 1;

	localparam logic [CFG_COLS_W-1:0] RESET_COLUMNS = 11'd8;
	localparam logic [WORD_W-1:0]     RESET_PATTERN = 40'h73706F6F6E;
	localparam logic [ROWS_W-1:0]     ROWS_FULL     = ROWS_W'(WINDOW_BACK);

	typedef enum logic {
		CFG_COLUMN_COUNT = 1'b0,
		CFG_PATTERN_WORD = 1'b1
	} cfg_index_t;

	// word handed from the front stage to the column stage
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
		logic              rows_zero;
		logic              rows_full;
		logic              last;
		logic              row_hit;
	} item_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

/* rtl/gws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/gws_front.sv */
// Front stage: case folding, row window match, column position and row count.
// Depends on gws_pkg.
module gws_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       grid_char,
	input  logic                             last_of_grid,
	input  logic [gws_pkg::CFG_COLS_W-1:0]   column_count,
	input  logic [gws_pkg::WORD_W-1:0]       pattern_word,
	input  logic                             hold,
	output logic                             accept,
	output gws_pkg::item_t                   item
);
	import gws_pkg::*;

	logic [ADDR_W-1:0] pos_q;
	logic [HIST_W-1:0] row_hist_q;
	logic [ROWS_W-1:0] rows_q;
	logic              row_hit_q;

	logic [CHAR_W-1:0] ch_f;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  max_ext;
	logic [CMP_W-1:0]  cols;
	logic [CMP_W-1:0]  pos_inc;
	logic              wrap;
	logic              row_match;
	logic              row_hit_nx;

	assign in_stall = hold;
	assign accept   = in_valid && !hold;
	assign ch_f     = fold_char(grid_char);

	always_comb begin
		cnt_ext = CMP_W'(column_count);
		max_ext = CMP_W'(MAX_COLUMNS);
		if (cnt_ext == '0) begin
			cols = CMP_W'(1);
		end else if (cnt_ext > max_ext) begin
			cols = max_ext;
		end else begin
			cols = cnt_ext;
		end
		pos_inc    = CMP_W'(pos_q) + CMP_W'(1);
		wrap       = pos_inc >= cols;
		row_match  = (pos_q >= ADDR_W'(WINDOW_BACK)) && ({row_hist_q, ch_f} == pattern_word);
		row_hit_nx = row_hit_q || row_match;
	end

	always_comb begin
		item.ch        = ch_f;
		item.addr      = pos_q;
		item.rows_zero = (rows_q == '0);
		item.rows_full = (rows_q == ROWS_FULL);
		item.last      = last_of_grid;
		item.row_hit   = row_hit_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			row_hist_q <= '0;
			rows_q     <= '0;
			row_hit_q  <= 1'b0;
		end else if (accept) begin
			if (last_of_grid) begin
				pos_q      <= '0;
				row_hist_q <= '0;
				rows_q     <= '0;
				row_hit_q  <= 1'b0;
			end else if (wrap) begin
				pos_q      <= '0;
				row_hist_q <= '0;
				row_hit_q  <= row_hit_nx;
				if (rows_q < ROWS_FULL) begin
					rows_q <= rows_q + ROWS_W'(1);
				end
			end else begin
				pos_q      <= pos_inc[ADDR_W-1:0];
				row_hist_q <= {row_hist_q[HIST_W-CHAR_W-1:0], ch_f};
				row_hit_q  <= row_hit_nx;
			end
		end
	end

	a_rows_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= ROWS_FULL)
		else $error("row count beyond saturation");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(pos_q) < CMP_W'(MAX_COLUMNS))
		else $error("column position out of range");

	a_grid_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_of_grid |=> pos_q == '0 && rows_q == '0 && !row_hit_q)
		else $error("grid state not cleared after final word");

endmodule

/* rtl/gws_col.sv */
// Column stage: read-modify-write of the column history with forwarding,
// column window match, hit accumulation and the result register.
// Depends on gws_pkg.
module gws_col (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  gws_pkg::item_t                   item,
	input  logic [gws_pkg::WORD_W-1:0]       pattern_word,
	input  logic [gws_pkg::HIST_W-1:0]       rd_data,
	output logic                             wr_en,
	output logic [gws_pkg::ADDR_W-1:0]       wr_addr,
	output logic [gws_pkg::HIST_W-1:0]       wr_data,
	output logic                             hold,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found_in_row,
	output logic                             found_in_column,
	output logic                             found_any
);
	import gws_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              col_hit_q;
	logic              wr_valid_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [HIST_W-1:0] wr_data_q;
	logic              out_valid_q;
	logic              row_q;
	logic              col_q;
	logic              any_q;

	logic              advance;
	logic              fwd;
	logic [HIST_W-1:0] above;
	logic              col_match;
	logic              col_hit_nx;

	always_comb begin
		hold       = valid_s1 && item_s1.last && out_valid_q && out_stall;
		advance    = valid_s1 && !hold;
		fwd        = wr_valid_q && (wr_addr_q == item_s1.addr);
		if (item_s1.rows_zero) begin
			above = '0;
		end else if (fwd) begin
			above = wr_data_q;
		end else begin
			above = rd_data;
		end
		col_match  = item_s1.rows_full && ({above, item_s1.ch} == pattern_word);
		col_hit_nx = col_hit_q || col_match;
	end

	assign wr_en   = advance;
	assign wr_addr = item_s1.addr;
	assign wr_data = {above[HIST_W-CHAR_W-1:0], item_s1.ch};

	assign out_valid       = out_valid_q;
	assign found_in_row    = row_q;
	assign found_in_column = col_q;
	assign found_any       = any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			item_s1     <= '0;
			col_hit_q   <= 1'b0;
			wr_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				item_s1  <= item;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				wr_valid_q <= 1'b1;
				col_hit_q  <= item_s1.last ? 1'b0 : col_hit_nx;
			end
			if (advance && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_addr_q <= item_s1.addr;
			wr_data_q <= wr_data;
		end
		if (advance && item_s1.last) begin
			row_q <= item_s1.row_hit;
			col_q <= col_hit_nx;
			any_q <= item_s1.row_hit || col_hit_nx;
		end
	end

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last |=> out_valid_q && found_in_column == $past(col_hit_nx))
		else $error("final word did not load the result");

	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> wr_valid_q && wr_addr_q == $past(item_s1.addr))
		else $error("forwarding register missed a write");

	a_any: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> found_any == (found_in_row || found_in_column))
		else $error("found_any inconsistent");

endmodule

/* rtl/grid_word_search_unit.sv */
// Grid word search unit: row and column five-letter match over a streamed grid.
// Result: the final grid word passes the column stage register and then loads the result register.
// Throughput: one grid word per cycle; the input stalls only while a final word waits
// behind a stalled result. Column history RAM read/write is pipelined with forwarding.
// Reset clears positions, counts and hits and loads the default column count and
// pattern; the column history RAM is not cleared (read only after a write in the grid).
module grid_word_search_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      grid_char,
	input  logic                            last_of_grid,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found_in_row,
	output logic                            found_in_column,
	output logic                            found_any,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  gws_pkg::cfg_index_t             cfg_index,
	input  logic [gws_pkg::WORD_W-1:0]      cfg_data
);
	import gws_pkg::*;

	logic [CFG_COLS_W-1:0] column_count_q;
	logic [WORD_W-1:0]     pattern_word_q;

	logic              accept;
	logic              hold;
	item_t             item;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [HIST_W-1:0] wr_data;
	logic [HIST_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= RESET_COLUMNS;
			pattern_word_q <= RESET_PATTERN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLUMN_COUNT: column_count_q <= cfg_data[CFG_COLS_W-1:0];
				CFG_PATTERN_WORD: pattern_word_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	gws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.grid_char    (grid_char),
		.last_of_grid (last_of_grid),
		.column_count (column_count_q),
		.pattern_word (pattern_word_q),
		.hold         (hold),
		.accept       (accept),
		.item         (item)
	);

	gws_ram #(
		.WIDTH (HIST_W),
		.DEPTH (MAX_COLUMNS)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (item.addr),
		.rd_data (rd_data)
	);

	gws_col u_col (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.item            (item),
		.pattern_word    (pattern_word_q),
		.rd_data         (rd_data),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.hold            (hold),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_in_row    (found_in_row),
		.found_in_column (found_in_column),
		.found_any       (found_any)
	);

endmodule

/* sim/tb.sv */
// Testbench for grid_word_search_unit: streams character grids and checks the
// row/column hit flags against an in-bench predictor. Depends on rtl/gws_pkg.sv
// and rtl/grid_word_search_unit.sv.
`timescale 1ns / 1ps

module tb;
	import gws_pkg::*;

	typedef struct packed {
		logic row_found;
		logic col_found;
		logic any_found;
	} hit_t;

	class grid_hit_tracker;
		bit [HIST_W-1:0]     col_hist [MAX_COLUMNS];
		bit [HIST_W-1:0]     row_hist;
		int unsigned         col_pos;
		int unsigned         rows_done;
		bit                  row_hit;
		bit                  col_hit;
		bit [CFG_COLS_W-1:0] col_cfg;
		bit [WORD_W-1:0]     pattern;
		hit_t                expected_hits[$];
		int unsigned         mismatches;

		function new();
			row_hist   = '0;
			col_pos    = 0;
			rows_done  = 0;
			row_hit    = 1'b0;
			col_hit    = 1'b0;
			col_cfg    = RESET_COLUMNS;
			pattern    = RESET_PATTERN;
			mismatches = 0;
		endfunction

		function int unsigned span();
			if (col_cfg == 0) return 1;
			if (col_cfg > MAX_COLUMNS) return MAX_COLUMNS;
			return col_cfg;
		endfunction

		function void apply_config(cfg_index_t idx, bit [WORD_W-1:0] d);
			if (idx == CFG_COLUMN_COUNT) begin
				col_cfg = d[CFG_COLS_W-1:0];
			end else begin
				pattern = d;
			end
		endfunction

		function void note_word(bit [CHAR_W-1:0] c, bit fin);
			bit [CHAR_W-1:0] f;
			bit [HIST_W-1:0] above;
			int unsigned     pos;
			hit_t            h;
			f = c;
			if (c >= "A" && c <= "Z") f = c + 8'h20;
			pos = col_pos;
			if (pos >= MAX_COLUMNS) pos = MAX_COLUMNS - 1;
			if (pos >= WINDOW_BACK && {row_hist, f} == pattern) row_hit = 1'b1;
			above = (rows_done == 0) ? '0 : col_hist[pos];
			if (rows_done >= WINDOW_BACK && {above, f} == pattern) col_hit = 1'b1;
			col_hist[pos] = {above[HIST_W-CHAR_W-1:0], f};
			row_hist = {row_hist[HIST_W-CHAR_W-1:0], f};
			if (pos + 1 >= span()) begin
				col_pos  = 0;
				row_hist = '0;
				if (rows_done < WINDOW_BACK) rows_done++;
			end else begin
				col_pos = pos + 1;
			end
			if (fin) begin
				h.row_found = row_hit;
				h.col_found = col_hit;
				h.any_found = row_hit | col_hit;
				expected_hits.push_back(h);
				row_hist  = '0;
				col_pos   = 0;
				rows_done = 0;
				row_hit   = 1'b0;
				col_hit   = 1'b0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic r, logic c, logic a);
			hit_t e;
			if (expected_hits.size() == 0) begin
				report($sformatf("unexpected word row=%b col=%b any=%b", r, c, a));
				return;
			end
			e = expected_hits.pop_front();
			if (r !== e.row_found)
				report($sformatf("found_in_row %b, expected %b", r, e.row_found));
			if (c !== e.col_found)
				report($sformatf("found_in_column %b, expected %b", c, e.col_found));
			if (a !== e.any_found)
				report($sformatf("found_any %b, expected %b", a, e.any_found));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        grid_char;
	logic              last_of_grid;
	logic              out_valid;
	logic              out_stall;
	logic              found_in_row;
	logic              found_in_column;
	logic              found_any;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_index_t        cfg_index;
	logic [WORD_W-1:0] cfg_data;

	grid_hit_tracker sb;
	int              words_taken;
	int              results_seen;
	int              gap_pct;
	int              stall_pct;
	int              hold_cycles;

	grid_word_search_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.grid_char       (grid_char),
		.last_of_grid    (last_of_grid),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_in_row    (found_in_row),
		.found_in_column (found_in_column),
		.found_any       (found_any),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.apply_config(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				sb.note_word(grid_char, last_of_grid);
				words_taken++;
			end
			if (out_valid && !out_stall) begin
				sb.check_result(found_in_row, found_in_column, found_any);
				results_seen++;
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [7:0] vary_case(logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(1) == 1) return c - 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] pick_char(logic [WORD_W-1:0] pat);
		int k;
		k = $urandom_range(4);
		case ($urandom_range(9))
			0: return 8'($urandom);
			1, 2, 3, 4, 5, 6: return vary_case(pat[WORD_W-1-8*k -: 8]);
			default: return vary_case(8'h61 + 8'($urandom_range(25)));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] w;
		logic [7:0]        b;
		w = '0;
		for (int k = 0; k < 5; k++) begin
			case ($urandom_range(5))
				0: b = "s";
				1: b = "p";
				2: b = "o";
				3: b = "n";
				default: b = 8'h61 + 8'($urandom_range(25));
			endcase
			w = {w[WORD_W-9:0], b};
		end
		return w;
	endfunction

	task automatic send_word(logic [7:0] ch, logic fin);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		grid_char    <= ch;
		last_of_grid <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_bytes(string s, logic fin);
		for (int i = 0; i < s.len(); i++) send_word(s[i], fin && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_hits.size() != 0) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_COLS_W-1:0] cols, logic [WORD_W-1:0] pat);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_COLUMN_COUNT;
		cfg_data  <= WORD_W'(cols);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_PATTERN_WORD;
		cfg_data  <= pat;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// grid of full rows plus a partial tail row, with optional planted words
	task automatic send_grid(int rows, int tail, bit row_word, bit col_word);
		int                cols;
		int                n;
		int                r;
		int                c;
		logic [7:0]        g[];
		logic [WORD_W-1:0] pat;
		cols = sb.span();
		pat  = sb.pattern;
		n    = rows * cols + tail;
		if (n == 0) n = 1;
		g = new[n];
		foreach (g[i]) g[i] = pick_char(pat);
		if (row_word && rows > 0 && cols >= 5) begin
			r = $urandom_range(rows - 1);
			c = $urandom_range(cols - 5);
			for (int k = 0; k < 5; k++)
				g[r*cols + c + k] = vary_case(pat[WORD_W-1-8*k -: 8]);
		end
		if (col_word && rows >= 5) begin
			r = $urandom_range(rows - 5);
			c = $urandom_range(cols - 1);
			for (int k = 0; k < 5; k++)
				g[(r+k)*cols + c] = vary_case(pat[WORD_W-1-8*k -: 8]);
		end
		foreach (g[i]) send_word(g[i], i == n - 1);
	endtask

	initial begin
		int                   phase;
		int                   budget;
		int                   rows;
		int                   tail;
		int                   span_now;
		logic [CFG_COLS_W-1:0] cols;
		logic [WORD_W-1:0]     pat;

		sb           = new();
		words_taken  = 0;
		results_seen = 0;
		gap_pct      = 6;
		stall_pct    = 6;
		hold_cycles  = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		grid_char    = '0;
		last_of_grid = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_COLUMN_COUNT;
		cfg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset pattern with mixed case, grid ends mid-row
		send_bytes("sPoOn", 1'b1);
		// zero columns act as one: word runs down the single column
		configure('0, RESET_PATTERN);
		send_bytes("SpooN", 1'b1);
		// oversize count clamps, so no row break at 8; all-ones pattern
		configure('1, '1);
		send_word(8'h00, 1'b0);
		send_bytes("@AZ[", 1'b0);
		send_word(8'h60, 1'b0);
		send_word("{", 1'b0);
		for (int k = 0; k < 5; k++) send_word(8'hFF, k == 4);
		// uppercase pattern byte never matches folded text
		configure(11'd5, 40'h53504F4F4E);
		send_bytes("SPOON", 1'b1);
		// shrink mid-row: next char closes the row
		configure(11'd8, RESET_PATTERN);
		send_bytes("abcde", 1'b0);
		configure(11'd5, RESET_PATTERN);
		send_bytes("xSpoon", 1'b1);

		phase = 0;
		while (words_taken < 1250 || results_seen < 48) begin
			pat  = rand_word();
			cols = CFG_COLS_W'($urandom_range(5, 12));
			case (phase % 8)
				1: cols = CFG_COLS_W'($urandom_range(1, 3));
				3: if (phase == 3) cols = '1;
				4: begin
					cols = '0;
					pat  = '0;
				end
				5: begin
					cols = 11'd7;
					pat  = '1;
				end
				6: pat = WORD_W'({$urandom, $urandom});
				7: cols = CFG_COLS_W'($urandom_range(4, 16));
				default: ;
			endcase
			configure(cols, pat);
			gap_pct   = (phase % 8 == 2) ? 0 : 6;
			stall_pct = gap_pct;
			if (phase % 8 == 1) hold_cycles = 300;
			if (phase == 3) begin
				// one long partial row at the widest grid
				send_grid(0, 160, 1'b0, 1'b0);
			end else begin
				budget = words_taken + 160;
				while (words_taken < budget) begin
					span_now = sb.span();
					rows = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 7);
					tail = 0;
					if (span_now > 1 && $urandom_range(3) == 0)
						tail = $urandom_range(span_now - 1);
					send_grid(rows, tail, $urandom_range(1), $urandom_range(1));
				end
			end
			phase++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
